@@ design/echo_pulse_range_meter_unit_macros.svh @@
// Assertion macros shared by the range meter checker.
`ifndef ECHO_PULSE_RANGE_METER_UNIT_MACROS_SVH
`define ECHO_PULSE_RANGE_METER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define EPR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("range meter check failed");

// Next-cycle implication, disabled during reset.
`define EPR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("range meter check failed");

`endif

@@ design/epr_pkg.sv @@
// Types and constants shared by the range meter modules.
package epr_pkg;

   localparam logic [1:0] REQ_START = 2'd0;
   localparam logic [1:0] REQ_EDGE  = 2'd1;
   localparam logic [1:0] REQ_TICK  = 2'd2;

   localparam logic [15:0]        TIMEOUT_RESET   = 16'd6000;
   localparam logic [15:0]        SPEED_RESET     = 16'd33140;
   localparam logic signed [16:0] SPEED_BASE      = 17'sd33140;
   localparam logic signed [16:0] SPEED_PER_TENTH = 17'sd6;
   localparam logic [15:0]        DUTY_SCALE      = 16'd25600;
   localparam logic [16:0]        DIST_DIVISOR    = 17'd125000;
   localparam logic [14:0]        DIST_MAX        = 15'd32767;
   localparam logic [14:0]        TIMEOUT_DIST    = 15'd25600;

   // floor(x / 125000) = ((x >> 3) * DIST_RECIP) >> 43 for every x below DIST_SAT_PRODUCT
   localparam logic [31:0]        DIST_SAT_PRODUCT = 32'd4096000000;
   localparam logic [29:0]        DIST_RECIP       = 30'd562949954;
   localparam int                 DIST_PRE_SHIFT   = 3;
   localparam int                 DIST_RECIP_SHIFT = 43;

   typedef enum logic [3:0] {
      PH_IDLE  = 4'b0001,
      PH_RISE1 = 4'b0010,
      PH_RISE2 = 4'b0100,
      PH_FALL  = 4'b1000
   } phase_type;

   typedef enum logic [6:0] {
      C_IDLE     = 7'b0000001,
      C_MOD      = 7'b0000010,
      C_DUTY_MUL = 7'b0000100,
      C_DUTY_DIV = 7'b0001000,
      C_DIST_MUL = 7'b0010000,
      C_DIST_DIV = 7'b0100000,
      C_DONE     = 7'b1000000
   } calc_state_type;

   typedef struct packed {
      logic start;
      logic ack;
   } calc_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } calc_sts_type;

endpackage

@@ design/epr_channels.sv @@
// Handshake channel interfaces of the range meter.
interface epr_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        req_type;
   logic signed [11:0] temperature_tenths;
   logic              edge_falling;
   logic [15:0]       edge_time;

   modport source (output valid, req_type, temperature_tenths, edge_falling, edge_time,
                   input ready);
   modport sink (input valid, req_type, temperature_tenths, edge_falling, edge_time,
                 output ready);
endinterface

interface epr_rsp_if;
   logic        valid;
   logic        ready;
   logic        timed_out;
   logic [15:0] period_ticks;
   logic [15:0] width_ticks;
   logic [14:0] duty_q8;
   logic [14:0] distance_q8;
   logic        zero_period;

   modport source (output valid, timed_out, period_ticks, width_ticks, duty_q8,
                   distance_q8, zero_period, input ready);
   modport sink (input valid, timed_out, period_ticks, width_ticks, duty_q8,
                 distance_q8, zero_period, output ready);
endinterface

interface epr_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

@@ design/epr_div.sv @@
// Restoring divider, one quotient bit per cycle, shared by the modulo and duty divisions.
module epr_div #(
   parameter int DIVW = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [DIVW-1:0] dividend,
   input  logic [DIVW-1:0] divisor,
   output logic            done,
   output logic [DIVW-1:0] quot,
   output logic [DIVW-1:0] rem
);
   localparam int CW = $clog2(DIVW);

   logic [DIVW-1:0] acc_ff, acc_in;
   logic [DIVW-1:0] q_ff, q_in;
   logic [DIVW-1:0] dvs_ff, dvs_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [DIVW:0]   shifted;
   logic [DIVW:0]   diff;

   always_comb begin
      shifted = {acc_ff, q_ff[DIVW-1]};
      diff    = shifted - {1'b0, dvs_ff};
      acc_in  = acc_ff;
      q_in    = q_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = '0;
         q_in    = dividend;
         dvs_in  = divisor;
         cnt_in  = CW'(DIVW - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // keep the trial difference only when it does not borrow
         if (!diff[DIVW]) begin
            acc_in = diff[DIVW-1:0];
         end else begin
            acc_in = shifted[DIVW-1:0];
         end
         q_in = {q_ff[DIVW-2:0], !diff[DIVW]};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      q_ff   <= q_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = q_ff;
   assign rem  = acc_ff;
endmodule

@@ design/epr_calc.sv @@
// Sequencer: modulo and duty through one divider, distance by reciprocal multiplication.
module epr_calc #(
   parameter int STAMP_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  epr_pkg::calc_ctl_type ctl,
   input  logic [STAMP_BITS-1:0] period,
   input  logic [STAMP_BITS-1:0] width_raw,
   input  logic [15:0]           speed,
   output epr_pkg::calc_sts_type sts,
   output logic [15:0]           period_ticks,
   output logic [15:0]           width_ticks,
   output logic [14:0]           duty_q8,
   output logic [14:0]           distance_q8,
   output logic                  zero_period
);
   import epr_pkg::*;

   localparam int DIVW = STAMP_BITS + 16;

   calc_state_type          state_ff, state_in;
   logic [STAMP_BITS-1:0]   per_ff, per_in;
   logic [STAMP_BITS-1:0]   wid_ff, wid_in;
   logic [15:0]             speed_ff, speed_in;
   logic [14:0]             duty_ff, duty_in;
   logic [14:0]             dist_ff, dist_in;
   logic                    zp_ff, zp_in;
   logic [DIVW-1:0]         dprod_ff, dprod_in;

   logic                    div_start;
   logic [DIVW-1:0]         div_dividend;
   logic [DIVW-1:0]         div_divisor;
   logic                    div_done;
   logic [DIVW-1:0]         div_quot;
   logic [DIVW-1:0]         div_rem;
   logic [15:0]             mul_b;
   logic [DIVW-1:0]         product;
   logic [DIVW-1:0]         per_ext;
   logic [DIVW-1:0]         wid_ext;
   logic [63:0]             dprod_wide;
   logic [28:0]             dist_y;
   logic [58:0]             recip_prod;

   // the divider's operand register follows the multiplier
   assign mul_b   = (state_ff == C_DUTY_MUL) ? DUTY_SCALE : speed_ff;
   assign product = DIVW'(wid_ff) * DIVW'(mul_b);
   assign per_ext = DIVW'(per_ff);
   assign wid_ext = DIVW'(wid_ff);

   assign dprod_wide = 64'(dprod_ff);
   assign dist_y     = dprod_wide[DIST_PRE_SHIFT+28:DIST_PRE_SHIFT];
   assign recip_prod = 59'(dist_y) * 59'(DIST_RECIP);

   always_comb begin
      state_in     = state_ff;
      per_in       = per_ff;
      wid_in       = wid_ff;
      speed_in     = speed_ff;
      duty_in      = duty_ff;
      dist_in      = dist_ff;
      zp_in        = zp_ff;
      dprod_in     = dprod_ff;
      div_start    = 1'b0;
      div_dividend = product;
      div_divisor  = DIVW'(per_ff);
      case (state_ff)
         C_IDLE: begin
            if (ctl.start) begin
               per_in   = period;
               speed_in = speed;
               if (period == '0) begin
                  wid_in   = '0;
                  duty_in  = '0;
                  dist_in  = '0;
                  zp_in    = 1'b1;
                  state_in = C_DONE;
               end else begin
                  zp_in        = 1'b0;
                  div_start    = 1'b1;
                  div_dividend = DIVW'(width_raw);
                  div_divisor  = DIVW'(period);
                  state_in     = C_MOD;
               end
            end
         end
         C_MOD: begin
            if (div_done) begin
               wid_in   = div_rem[STAMP_BITS-1:0];
               state_in = C_DUTY_MUL;
            end
         end
         C_DUTY_MUL: begin
            div_start = 1'b1;
            state_in  = C_DUTY_DIV;
         end
         C_DUTY_DIV: begin
            if (div_done) begin
               duty_in  = div_quot[14:0];
               state_in = C_DIST_MUL;
            end
         end
         C_DIST_MUL: begin
            // hold width times speed for the reciprocal multiply
            dprod_in = product;
            state_in = C_DIST_DIV;
         end
         C_DIST_DIV: begin
            // saturate before narrowing to the field
            if (dprod_wide >= 64'(DIST_SAT_PRODUCT)) begin
               dist_in = DIST_MAX;
            end else begin
               dist_in = recip_prod[DIST_RECIP_SHIFT+14:DIST_RECIP_SHIFT];
            end
            state_in = C_DONE;
         end
         C_DONE: begin
            if (ctl.ack) begin
               state_in = C_IDLE;
            end
         end
         default: begin
            state_in = C_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      per_ff   <= per_in;
      wid_ff   <= wid_in;
      speed_ff <= speed_in;
      duty_ff  <= duty_in;
      dist_ff  <= dist_in;
      zp_ff    <= zp_in;
      dprod_ff <= dprod_in;
      if (reset) begin
         state_ff <= C_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   epr_div #(
      .DIVW (DIVW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   assign sts.busy     = (state_ff != C_IDLE);
   assign sts.done     = (state_ff == C_DONE);
   assign period_ticks = per_ext[15:0];
   assign width_ticks  = wid_ext[15:0];
   assign duty_q8      = duty_ff;
   assign distance_q8  = dist_ff;
   assign zero_period  = zp_ff;
endmodule

@@ design/echo_pulse_range_meter_unit.sv @@
// A tick that times out offers its result item in the following cycle. The closing falling edge
// starts the arithmetic sequencer, which runs modulo and duty through the divider (one quotient
// bit per cycle) and distance by reciprocal multiplication before the item is offered; a zero
// period skips the arithmetic. No input item is taken meanwhile, nor while a result item waits
// for the sink.
// Synchronous active-high reset: idle, timeout limit 6000, speed 33140, counters clear.
module echo_pulse_range_meter_unit #(
   parameter int STAMP_BITS = 16
) (
   input logic      clock,
   input logic      reset,
   epr_req_if.sink  req_ch,
   epr_rsp_if.source rsp_ch,
   epr_csr_if.sink  csr_ch
);
   import epr_pkg::*;

   localparam int EXTW = STAMP_BITS + 16;

   phase_type             phase_ff, phase_in;
   logic [STAMP_BITS-1:0] first_ff, first_in;
   logic [STAMP_BITS-1:0] second_ff, second_in;
   logic [15:0]           wait_ff, wait_in;
   logic [15:0]           speed_ff, speed_in;
   logic [15:0]           timeout_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  to_ff;
   logic [15:0]           per_out_ff;
   logic [15:0]           wid_out_ff;
   logic [14:0]           duty_out_ff;
   logic [14:0]           dist_out_ff;
   logic                  zp_out_ff;

   calc_ctl_type          calc_ctl;
   calc_sts_type          calc_sts;
   logic [15:0]           calc_per;
   logic [15:0]           calc_wid;
   logic [14:0]           calc_duty;
   logic [14:0]           calc_dist;
   logic                  calc_zp;

   logic                  slot_free;
   logic                  accept;
   logic                  timeout_hit;
   logic [EXTW-1:0]       edge_ext;
   logic [STAMP_BITS-1:0] stamp;
   logic [STAMP_BITS-1:0] period;
   logic [STAMP_BITS-1:0] width_raw;
   logic signed [16:0]    tenths_ext;
   logic signed [16:0]    speed_sum;

   assign slot_free     = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready  = !calc_sts.busy && slot_free;
   assign accept        = req_ch.valid && req_ch.ready;
   assign csr_ch.ready  = 1'b1;

   assign edge_ext   = EXTW'(req_ch.edge_time);
   assign stamp      = edge_ext[STAMP_BITS-1:0];
   assign period     = second_ff - first_ff;
   assign width_raw  = stamp - second_ff;
   assign tenths_ext = 17'(req_ch.temperature_tenths);
   assign speed_sum  = SPEED_BASE + tenths_ext * SPEED_PER_TENTH;

   always_comb begin
      phase_in       = phase_ff;
      first_in       = first_ff;
      second_in      = second_ff;
      wait_in        = wait_ff;
      speed_in       = speed_ff;
      timeout_hit    = 1'b0;
      calc_ctl.start = 1'b0;
      calc_ctl.ack   = calc_sts.done && slot_free;
      if (accept) begin
         case (req_ch.req_type)
            REQ_START: begin
               speed_in = speed_sum[15:0];
               phase_in = PH_RISE1;
               wait_in  = '0;
            end
            REQ_TICK: begin
               if (phase_ff != PH_IDLE) begin
                  if (wait_ff >= timeout_ff) begin
                     timeout_hit = 1'b1;
                     phase_in    = PH_IDLE;
                     wait_in     = '0;
                  end else begin
                     wait_in = wait_ff + 1'b1;
                  end
               end
            end
            REQ_EDGE: begin
               // drop edges of the wrong polarity without touching the wait count
               case (phase_ff)
                  PH_RISE1: begin
                     if (!req_ch.edge_falling) begin
                        first_in = stamp;
                        phase_in = PH_RISE2;
                        wait_in  = '0;
                     end
                  end
                  PH_RISE2: begin
                     if (!req_ch.edge_falling) begin
                        second_in = stamp;
                        phase_in  = PH_FALL;
                        wait_in   = '0;
                     end
                  end
                  PH_FALL: begin
                     if (req_ch.edge_falling) begin
                        calc_ctl.start = 1'b1;
                        phase_in       = PH_IDLE;
                        wait_in        = '0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (timeout_hit || calc_ctl.ack) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         first_ff     <= '0;
         second_ff    <= '0;
         wait_ff      <= '0;
         speed_ff     <= SPEED_RESET;
         timeout_ff   <= TIMEOUT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         first_ff     <= first_in;
         second_ff    <= second_in;
         wait_ff      <= wait_in;
         speed_ff     <= speed_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_ch.valid) begin
            timeout_ff <= csr_ch.data;
         end
      end
   end

   // hold the result item until the sink takes it
   always_ff @(posedge clock) begin
      if (timeout_hit) begin
         to_ff       <= 1'b1;
         per_out_ff  <= '0;
         wid_out_ff  <= '0;
         duty_out_ff <= '0;
         dist_out_ff <= TIMEOUT_DIST;
         zp_out_ff   <= 1'b0;
      end else if (calc_ctl.ack) begin
         to_ff       <= 1'b0;
         per_out_ff  <= calc_per;
         wid_out_ff  <= calc_wid;
         duty_out_ff <= calc_duty;
         dist_out_ff <= calc_dist;
         zp_out_ff   <= calc_zp;
      end
   end

   epr_calc #(
      .STAMP_BITS (STAMP_BITS)
   ) u_calc (
      .clock        (clock),
      .reset        (reset),
      .ctl          (calc_ctl),
      .period       (period),
      .width_raw    (width_raw),
      .speed        (speed_ff),
      .sts          (calc_sts),
      .period_ticks (calc_per),
      .width_ticks  (calc_wid),
      .duty_q8      (calc_duty),
      .distance_q8  (calc_dist),
      .zero_period  (calc_zp)
   );

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.timed_out    = to_ff;
   assign rsp_ch.period_ticks = per_out_ff;
   assign rsp_ch.width_ticks  = wid_out_ff;
   assign rsp_ch.duty_q8      = duty_out_ff;
   assign rsp_ch.distance_q8  = dist_out_ff;
   assign rsp_ch.zero_period  = zp_out_ff;
endmodule

@@ design/epr_check.sv @@
// Port-level checker for the range meter and its bind to the top level.
`include "echo_pulse_range_meter_unit_macros.svh"

module epr_check (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        timed_out,
   input logic [15:0] period_ticks,
   input logic [15:0] width_ticks,
   input logic [14:0] duty_q8,
   input logic [14:0] distance_q8,
   input logic        zero_period
);
   `EPR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   `EPR_ASSERT_NOW(a_timeout_item, clock, reset, rsp_valid && timed_out, (distance_q8 == 15'd25600) && (period_ticks == 16'd0) && (width_ticks == 16'd0) && (duty_q8 == 15'd0) && !zero_period)

   `EPR_ASSERT_NOW(a_zero_period_item, clock, reset, rsp_valid && zero_period, (width_ticks == 16'd0) && (duty_q8 == 15'd0) && (distance_q8 == 15'd0) && !timed_out)

   `EPR_ASSERT_NOW(a_duty_range, clock, reset, rsp_valid, duty_q8 < 15'd25600)
endmodule

bind echo_pulse_range_meter_unit epr_check u_epr_check (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .timed_out    (rsp_ch.timed_out),
   .period_ticks (rsp_ch.period_ticks),
   .width_ticks  (rsp_ch.width_ticks),
   .duty_q8      (rsp_ch.duty_q8),
   .distance_q8  (rsp_ch.distance_q8),
   .zero_period  (rsp_ch.zero_period)
);
